[rtl/mqpf_pkg.sv]
// Shared types and constants for the multi-queue packet FIFO.
// Used by the controller, the datapath and the top level; no dependencies.
package mqpf_pkg;

   // Result status codes
   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NOT_INIT = 3'd1,
      ST_INVALID  = 3'd2,
      ST_FULL     = 3'd3,
      ST_EMPTY    = 3'd4
   } status_type;

   // Operation codes
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // Configuration register indexes
   localparam logic [2:0] CSR_ENABLE = 3'd0;
   localparam logic [2:0] CSR_QUEUES = 3'd1;
   localparam logic [2:0] CSR_CAP0   = 3'd2;
   localparam logic [2:0] CSR_CAP1   = 3'd3;
   localparam logic [2:0] CSR_CAP2   = 3'd4;
   localparam logic [2:0] CSR_CAP3   = 3'd5;

   // Field widths
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 5;
   localparam int QNUM_W      = 3;
   localparam int STATUS_W    = 3;
   localparam int PKT_FIELD_W = 64;
   localparam int NUM_CAP_REGS = 4;
   localparam int CAP_REG_W   = 5;
   localparam int TDATA_W     = 72;

   // Controller states
   typedef enum logic [1:0] {
      S_IDLE,
      S_REDUCE,
      S_EXEC,
      S_DONE
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load_item;
      logic reduce_step;
      logic exec;
      logic load_rsp;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic reduce_done;
   } dp_status_type;

endpackage

[rtl/mqpf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mqpf_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic                                     re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/mqpf_ctrl.sv]
// Controller state machine for the multi-queue packet FIFO.
// Depends on mqpf_pkg; drives the datapath commands and both handshakes.
module mqpf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output mqpf_pkg::cmd_type      cmd,
   input  mqpf_pkg::dp_status_type dp_status
);

   mqpf_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mqpf_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output register can take a new result
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in        = state_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      req_tready      = 1'b0;
      cmd.load_item   = 1'b0;
      cmd.reduce_step = 1'b0;
      cmd.exec        = 1'b0;
      cmd.load_rsp    = 1'b0;
      unique case (state_ff)
         mqpf_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = mqpf_pkg::S_REDUCE;
            end
         end
         mqpf_pkg::S_REDUCE: begin
            // wrap a stale read pointer into the current capacity
            if (dp_status.reduce_done) begin
               state_in = mqpf_pkg::S_EXEC;
            end else begin
               cmd.reduce_step = 1'b1;
            end
         end
         mqpf_pkg::S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = mqpf_pkg::S_DONE;
         end
         mqpf_pkg::S_DONE: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = mqpf_pkg::S_IDLE;
            end
         end
         default: state_in = mqpf_pkg::S_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

[rtl/mqpf_dp.sv]
// Datapath for the multi-queue packet FIFO: configuration registers,
// per-queue pointers and counts, packet store and result register.
// Depends on mqpf_pkg and mqpf_ram.
module mqpf_dp #(
   parameter int NUM_QUEUES   = 4,
   parameter int QUEUE_DEPTH  = 16,
   parameter int PACKET_WIDTH = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [mqpf_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [mqpf_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                  in_op,
   input  logic [mqpf_pkg::QNUM_W-1:0]           in_qnum,
   input  logic [mqpf_pkg::PKT_FIELD_W-1:0]      in_packet,
   output mqpf_pkg::status_type                  out_status,
   output logic [mqpf_pkg::PKT_FIELD_W-1:0]      out_packet,
   input  mqpf_pkg::cmd_type                     cmd,
   output mqpf_pkg::dp_status_type               dp_status
);

   localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int RPW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW     = $clog2(QUEUE_DEPTH + 1);
   localparam int STORE_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
   localparam int AW     = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int WIDE_W = 10;

   // configuration registers
   logic                              enable_ff;
   logic [mqpf_pkg::QNUM_W-1:0]       queues_ff;
   logic [mqpf_pkg::CAP_REG_W-1:0]    cap_reg_ff [mqpf_pkg::NUM_CAP_REGS];

   // per-queue state
   logic [RPW-1:0] rp_tbl_ff  [NUM_QUEUES];
   logic [CW-1:0]  occ_tbl_ff [NUM_QUEUES];

   // current item
   logic                          op_ff;
   logic                          q_ok_ff;
   logic [QIDX_W-1:0]             qidx_ff;
   logic [PACKET_WIDTH-1:0]       pkt_ff;
   logic [RPW-1:0]                rp_w_ff;
   logic [CW-1:0]                 occ_w_ff;
   logic [CW-1:0]                 cap_w_ff;
   mqpf_pkg::status_type          st_ff;
   logic                          pop_ok_ff;

   // result register
   mqpf_pkg::status_type                 rsp_status_ff;
   logic [mqpf_pkg::PKT_FIELD_W-1:0]     rsp_packet_ff;

   // load-time lookups
   logic [mqpf_pkg::QNUM_W:0] limit;
   logic                      in_range;
   logic [QIDX_W-1:0]         in_qidx;
   logic [WIDE_W-1:0]         cap_raw;
   logic [CW-1:0]             cap_eff;

   // execute-time logic
   logic [CW-1:0]   rp_ext;
   logic            reduce_done;
   logic [CW:0]     push_sum;
   logic [CW:0]     push_slot_w;
   logic [RPW-1:0]  slot;
   logic [CW-1:0]   rp_inc;
   logic [RPW-1:0]  rp_next;
   mqpf_pkg::status_type exec_status;
   logic            push_ok, pop_ok;
   logic [AW-1:0]   addr;
   logic [PACKET_WIDTH-1:0] rd_data;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         queues_ff <= mqpf_pkg::QNUM_W'(4);
         for (int i = 0; i < mqpf_pkg::NUM_CAP_REGS; i++) begin
            cap_reg_ff[i] <= mqpf_pkg::CAP_REG_W'(16);
         end
      end else if (csr_we) begin
         unique case (csr_index)
            mqpf_pkg::CSR_ENABLE: enable_ff     <= csr_wdata[0];
            mqpf_pkg::CSR_QUEUES: queues_ff     <= csr_wdata[mqpf_pkg::QNUM_W-1:0];
            mqpf_pkg::CSR_CAP0:   cap_reg_ff[0] <= csr_wdata;
            mqpf_pkg::CSR_CAP1:   cap_reg_ff[1] <= csr_wdata;
            mqpf_pkg::CSR_CAP2:   cap_reg_ff[2] <= csr_wdata;
            mqpf_pkg::CSR_CAP3:   cap_reg_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // effective queue count and capacity of the addressed queue
   always_comb begin
      if ({1'b0, queues_ff} > (mqpf_pkg::QNUM_W + 1)'(NUM_QUEUES)) begin
         limit = (mqpf_pkg::QNUM_W + 1)'(NUM_QUEUES);
      end else begin
         limit = {1'b0, queues_ff};
      end
      in_range = {1'b0, in_qnum} < (mqpf_pkg::QNUM_W + 1)'(NUM_QUEUES);
      in_qidx  = in_range ? QIDX_W'(in_qnum) : '0;
      if (in_qnum < mqpf_pkg::QNUM_W'(mqpf_pkg::NUM_CAP_REGS)) begin
         cap_raw = WIDE_W'(cap_reg_ff[in_qnum[1:0]]);
      end else begin
         cap_raw = '0;
      end
      if (cap_raw > WIDE_W'(QUEUE_DEPTH)) begin
         cap_eff = CW'(QUEUE_DEPTH);
      end else begin
         cap_eff = cap_raw[CW-1:0];
      end
   end

   // capture the item and its queue state
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff    <= in_op;
         q_ok_ff  <= ({1'b0, in_qnum} < limit);
         qidx_ff  <= in_qidx;
         pkt_ff   <= in_packet[PACKET_WIDTH-1:0];
         rp_w_ff  <= rp_tbl_ff[in_qidx];
         occ_w_ff <= occ_tbl_ff[in_qidx];
         cap_w_ff <= cap_eff;
      end else if (cmd.reduce_step) begin
         rp_w_ff  <= RPW'(rp_ext - cap_w_ff);
      end
   end

   // pointer wrap, slot selection and status
   always_comb begin
      rp_ext      = CW'(rp_w_ff);
      reduce_done = (cap_w_ff == '0) || (rp_ext < cap_w_ff);
      push_sum    = (CW + 1)'(rp_w_ff) + (CW + 1)'(occ_w_ff);
      if (push_sum >= (CW + 1)'(cap_w_ff)) begin
         push_slot_w = push_sum - (CW + 1)'(cap_w_ff);
      end else begin
         push_slot_w = push_sum;
      end
      slot   = push_slot_w[RPW-1:0];
      rp_inc = rp_ext + CW'(1);
      if (rp_inc >= cap_w_ff) begin
         rp_next = '0;
      end else begin
         rp_next = rp_inc[RPW-1:0];
      end
      if (!enable_ff) begin
         exec_status = mqpf_pkg::ST_NOT_INIT;
      end else if (!q_ok_ff) begin
         exec_status = mqpf_pkg::ST_INVALID;
      end else if (cap_w_ff == '0) begin
         exec_status = mqpf_pkg::ST_NOT_INIT;
      end else if (op_ff == mqpf_pkg::OP_PUSH) begin
         exec_status = (occ_w_ff >= cap_w_ff) ? mqpf_pkg::ST_FULL : mqpf_pkg::ST_OK;
      end else begin
         exec_status = (occ_w_ff == '0) ? mqpf_pkg::ST_EMPTY : mqpf_pkg::ST_OK;
      end
      push_ok = cmd.exec && (exec_status == mqpf_pkg::ST_OK) && (op_ff == mqpf_pkg::OP_PUSH);
      pop_ok  = cmd.exec && (exec_status == mqpf_pkg::ST_OK) && (op_ff == mqpf_pkg::OP_POP);
      addr    = AW'(int'(qidx_ff) * QUEUE_DEPTH
                    + int'((op_ff == mqpf_pkg::OP_PUSH) ? slot : rp_w_ff));
   end

   assign dp_status.reduce_done = reduce_done;

   // per-queue pointer and count update
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_QUEUES; i++) begin
            rp_tbl_ff[i]  <= '0;
            occ_tbl_ff[i] <= '0;
         end
      end else if (push_ok) begin
         occ_tbl_ff[qidx_ff] <= occ_w_ff + CW'(1);
      end else if (pop_ok) begin
         rp_tbl_ff[qidx_ff]  <= rp_next;
         occ_tbl_ff[qidx_ff] <= occ_w_ff - CW'(1);
      end
   end

   // execute outcome
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         st_ff     <= exec_status;
         pop_ok_ff <= pop_ok;
      end
   end

   mqpf_ram #(
      .WIDTH (PACKET_WIDTH),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (push_ok),
      .waddr (addr),
      .wdata (pkt_ff),
      .re    (pop_ok),
      .raddr (addr),
      .rdata (rd_data)
   );

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff <= st_ff;
         rsp_packet_ff <= pop_ok_ff ? mqpf_pkg::PKT_FIELD_W'(rd_data) : '0;
      end
   end

   assign out_status = rsp_status_ff;
   assign out_packet = rsp_packet_ff;

endmodule

[rtl/multi_queue_packet_fifo_core.sv]
// Multi-queue packet FIFO, top level. Depends on mqpf_pkg, mqpf_ctrl, mqpf_dp.
// Sequence per request transaction: capture, pointer wrap (repeated while a read
// pointer sits beyond a shrunk queue capacity), store access and result load,
// which waits until the output register is free. A new request is accepted only
// once the controller is back in idle, after the result load.
// Reset: synchronous; queues empty, block disabled, 4 queues, capacities 16.
module multi_queue_packet_fifo_core #(
   parameter int NUM_QUEUES   = 4,
   parameter int QUEUE_DEPTH  = 16,
   parameter int PACKET_WIDTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [mqpf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mqpf_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [0] operation, [3:1] queue_number, [67:4] packet_in, [71:68] zero
   input  logic [mqpf_pkg::TDATA_W-1:0]      req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [2:0] status, [66:3] packet_out, [71:67] zero
   output logic [mqpf_pkg::TDATA_W-1:0]      rsp_tdata
);

   mqpf_pkg::cmd_type                cmd;
   mqpf_pkg::dp_status_type          dp_status;
   mqpf_pkg::status_type             out_status;
   logic [mqpf_pkg::PKT_FIELD_W-1:0] out_packet;

   mqpf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .dp_status  (dp_status)
   );

   mqpf_dp #(
      .NUM_QUEUES   (NUM_QUEUES),
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .PACKET_WIDTH (PACKET_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .in_op      (req_tdata[0]),
      .in_qnum    (req_tdata[3:1]),
      .in_packet  (req_tdata[67:4]),
      .out_status (out_status),
      .out_packet (out_packet),
      .cmd        (cmd),
      .dp_status  (dp_status)
   );

   // pack the result fields
   assign rsp_tdata = {5'd0, out_packet, out_status};

endmodule

[sim/mqpf_checker.sv]
// Scoreboard for the multi-queue packet FIFO. It tracks queue state from the
// observed CSR writes and request transactions, and checks every response.
// Depends on mqpf_pkg for status, operation and CSR index codes.
module mqpf_checker #(
   parameter int NUM_QUEUES  = 4,
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [mqpf_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [mqpf_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic                                   req_tvalid,
   input  logic                                   req_tready,
   input  logic [mqpf_pkg::TDATA_W-1:0]           req_tdata,
   input  logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   input  logic [mqpf_pkg::TDATA_W-1:0]           rsp_tdata,
   output int                                     mismatch_count,
   output int                                     results_pending,
   output int                                     results_checked,
   output logic [NUM_QUEUES-1:0][15:0]            queue_fill,
   output logic [NUM_QUEUES-1:0][QUEUE_DEPTH-1:0] slots_written
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      mqpf_pkg::status_type             status;
      logic [mqpf_pkg::PKT_FIELD_W-1:0] packet;
   } queue_result_type;

   // Shadow registers, reset values as in the block
   logic                             block_enabled;
   logic [2:0]                       queues_in_use;
   logic [mqpf_pkg::CAP_REG_W-1:0]   capacity_reg [mqpf_pkg::NUM_CAP_REGS];

   // Per-queue state
   int                               read_ptr [NUM_QUEUES];
   int                               fill [NUM_QUEUES];
   logic [mqpf_pkg::PKT_FIELD_W-1:0] packet_mem [NUM_QUEUES][QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]           written [NUM_QUEUES];

   queue_result_type                 predicted_rsp [$];
   int                               mismatches;
   int                               checked;

   function automatic int effective_capacity(int qnum);
      int cap;
      cap = (qnum < mqpf_pkg::NUM_CAP_REGS) ? int'(capacity_reg[qnum]) : 0;
      return (cap > QUEUE_DEPTH) ? QUEUE_DEPTH : cap;
   endfunction

   // Performs one push or pop on the shadow queues and returns its response
   function automatic queue_result_type apply_queue_op(
      logic op, logic [mqpf_pkg::QNUM_W-1:0] qnum,
      logic [mqpf_pkg::PKT_FIELD_W-1:0] pkt);
      queue_result_type res;
      int               limit;
      int               cap;
      int               rp;
      int               occ;
      int               slot;
      res.status = mqpf_pkg::ST_OK;
      res.packet = '0;
      limit = (queues_in_use > NUM_QUEUES) ? NUM_QUEUES : int'(queues_in_use);
      if (!block_enabled) begin
         res.status = mqpf_pkg::ST_NOT_INIT;
      end else if (qnum >= limit) begin
         res.status = mqpf_pkg::ST_INVALID;
      end else begin
         cap = effective_capacity(qnum);
         if (cap == 0) begin
            res.status = mqpf_pkg::ST_NOT_INIT;
         end else begin
            // pointer may sit beyond a shrunk capacity
            rp  = read_ptr[qnum] % cap;
            occ = fill[qnum];
            if (op == mqpf_pkg::OP_PUSH) begin
               if (occ >= cap) begin
                  res.status = mqpf_pkg::ST_FULL;
               end else begin
                  slot = (rp + occ) % cap;
                  packet_mem[qnum][slot] = pkt;
                  written[qnum][slot] = 1'b1;
                  fill[qnum] = occ + 1;
               end
            end else begin
               if (occ == 0) begin
                  res.status = mqpf_pkg::ST_EMPTY;
               end else begin
                  res.packet = packet_mem[qnum][rp];
                  read_ptr[qnum] = (rp + 1) % cap;
                  fill[qnum] = occ - 1;
               end
            end
         end
      end
      return res;
   endfunction

   function automatic void flag_error(string msg);
      mismatches++;
      if (mismatches <= 10) begin
         $display("[%0t] mqpf_checker: %s", $time, msg);
      end
   endfunction

   always @(posedge clock) begin : monitor
      queue_result_type                 exp_rsp;
      logic [mqpf_pkg::STATUS_W-1:0]    got_status;
      logic [mqpf_pkg::PKT_FIELD_W-1:0] got_packet;
      if (reset) begin
         block_enabled = 1'b0;
         queues_in_use = 3'd4;
         for (int i = 0; i < mqpf_pkg::NUM_CAP_REGS; i++) begin
            capacity_reg[i] = mqpf_pkg::CAP_REG_W'(16);
         end
         for (int i = 0; i < NUM_QUEUES; i++) begin
            read_ptr[i] = 0;
            fill[i] = 0;
            written[i] = '0;
         end
         predicted_rsp.delete();
         mismatches = 0;
         checked = 0;
      end else begin
         // CSR write; indexes past the last capacity register do nothing
         if (csr_we) begin
            case (csr_index) inside
               mqpf_pkg::CSR_ENABLE: block_enabled = csr_wdata[0];
               mqpf_pkg::CSR_QUEUES: queues_in_use = csr_wdata[2:0];
               mqpf_pkg::CSR_CAP0, mqpf_pkg::CSR_CAP1,
               mqpf_pkg::CSR_CAP2, mqpf_pkg::CSR_CAP3: begin
                  capacity_reg[2'(csr_index - mqpf_pkg::CSR_CAP0)] = csr_wdata;
               end
               default: ;
            endcase
         end

         // Response transaction against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got_status = rsp_tdata[2:0];
            got_packet = rsp_tdata[66:3];
            if (predicted_rsp.size() == 0) begin
               flag_error($sformatf("response with nothing outstanding: status %0d packet %h",
                                    got_status, got_packet));
            end else begin
               exp_rsp = predicted_rsp.pop_front();
               checked++;
               if (got_status !== exp_rsp.status) begin
                  flag_error($sformatf("status: expected %0d, got %0d",
                                       exp_rsp.status, got_status));
               end
               if (got_packet !== exp_rsp.packet) begin
                  flag_error($sformatf("packet: expected %h, got %h",
                                       exp_rsp.packet, got_packet));
               end
            end
         end

         // Request transaction: [0] op, [3:1] queue, [67:4] packet
         if (req_tvalid && req_tready) begin
            predicted_rsp.push_back(apply_queue_op(req_tdata[0], req_tdata[3:1],
                                                   req_tdata[67:4]));
         end
      end

      // Published through nonblocking assignments so the stimulus never races the update
      for (int i = 0; i < NUM_QUEUES; i++) begin
         queue_fill[i] <= 16'(fill[i]);
         slots_written[i] <= written[i];
      end
      results_pending <= predicted_rsp.size();
      mismatch_count <= mismatches;
      results_checked <= checked;
   end

endmodule

[sim/multi_queue_packet_fifo_core_tb.sv]
// Testbench top for multi_queue_packet_fifo_core: clock, reset, CSR setup,
// request stimulus with bursts, response back-pressure and the verdict.
// Depends on mqpf_pkg, mqpf_checker and the RTL of the block.
module multi_queue_packet_fifo_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_QUEUES       = 4;
   localparam int DEPTH          = 16;
   localparam int PKT_W          = 64;
   localparam int RANDOM_PHASES  = 12;
   localparam int PHASE_ITEMS    = 102;
   localparam int HOLD_PHASE     = 2;
   localparam int LONG_HOLD      = 400;
   localparam int SETTLE_CYCLES  = 24;
   localparam int CYCLE_LIMIT    = 600_000;

   // Indexes past the last register; writes there must be ignored
   localparam logic [mqpf_pkg::CSR_INDEX_W-1:0] CSR_SPARE6 = 3'd6;
   localparam logic [mqpf_pkg::CSR_INDEX_W-1:0] CSR_SPARE7 = 3'd7;

   localparam logic [PKT_W-1:0] PKT_ONES    = '1;
   localparam logic [PKT_W-1:0] PKT_ZERO    = '0;
   localparam logic [PKT_W-1:0] PKT_PATTERN = 64'hA5A5_5A5A_0F0F_F0F0;
   localparam logic [PKT_W-1:0] PKT_EDGES   = 64'h8000_0000_0000_0001;

   logic                             clock;
   logic                             reset;
   logic                             csr_we;
   logic [mqpf_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [mqpf_pkg::CSR_DATA_W-1:0]  csr_wdata;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [mqpf_pkg::TDATA_W-1:0]     req_tdata;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [mqpf_pkg::TDATA_W-1:0]     rsp_tdata;

   int                               mismatch_count;
   int                               results_pending;
   int                               results_checked;
   logic [N_QUEUES-1:0][15:0]        queue_fill;
   logic [N_QUEUES-1:0][DEPTH-1:0]   slots_written;

   int cycle_count = 0;
   int live_queues;
   int cap_now [N_QUEUES];
   int requests_sent;
   int busy_resizes;
   int long_holds_asked;
   int long_holds_served;

   multi_queue_packet_fifo_core #(
      .NUM_QUEUES   (N_QUEUES),
      .QUEUE_DEPTH  (DEPTH),
      .PACKET_WIDTH (PKT_W)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   mqpf_checker #(
      .NUM_QUEUES  (N_QUEUES),
      .QUEUE_DEPTH (DEPTH)
   ) i_checker (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending),
      .results_checked (results_checked),
      .queue_fill      (queue_fill),
      .slots_written   (slots_written)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, results_pending);
      $display("multi_queue_packet_fifo_core_tb failed");
      $finish;
   end

   // Response side: ready pattern changes mode now and then; long holds on request
   initial begin : sink
      int mode;
      int mode_left;
      int stall_left;
      int k;
      mode = 0;
      mode_left = 0;
      stall_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_holds_served != long_holds_asked) begin
            long_holds_served++;
            rsp_tready <= 1'b0;
            for (k = 0; k < LONG_HOLD; k++) @(posedge clock);
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 2);
            mode_left = $urandom_range(32, 256);
         end
         mode_left--;
         case (mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            default: begin
               if (stall_left > 0) begin
                  rsp_tready <= 1'b0;
                  stall_left--;
               end else begin
                  rsp_tready <= 1'b1;
                  if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 8);
               end
            end
         endcase
      end
   end

   // One request transaction; returns at the edge where it was accepted
   task automatic offer_request(logic op, logic [mqpf_pkg::QNUM_W-1:0] qnum,
                                logic [PKT_W-1:0] pkt);
      req_tdata <= {4'b0, pkt, qnum, op};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
   endtask

   // Leaves csr_we high; the caller lowers it after the last write
   task automatic write_reg(logic [mqpf_pkg::CSR_INDEX_W-1:0] idx,
                            logic [mqpf_pkg::CSR_DATA_W-1:0] value);
      csr_index <= idx;
      csr_wdata <= value;
      csr_we <= 1'b1;
      @(posedge clock);
   endtask

   task automatic set_capacity(int qnum, int value);
      if (queue_fill[qnum] != 0 && value != cap_now[qnum]) busy_resizes++;
      write_reg(mqpf_pkg::CSR_CAP0 + mqpf_pkg::CSR_INDEX_W'(qnum),
                mqpf_pkg::CSR_DATA_W'(value));
      cap_now[qnum] = value;
   endtask

   task automatic set_queue_count(int value);
      write_reg(mqpf_pkg::CSR_QUEUES, mqpf_pkg::CSR_DATA_W'(value));
      live_queues = (value > N_QUEUES) ? N_QUEUES : value;
   endtask

   // Stop offering and wait until every response is back and the block is quiet
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // A new capacity on a queue holding packets is only allowed once every
   // slot it can reach has been written, so no pop returns a stale entry.
   function automatic bit resize_is_safe(int qnum, int value);
      int eff;
      int s;
      eff = (value > DEPTH) ? DEPTH : value;
      if (queue_fill[qnum] == 0 || eff == 0) return 1'b1;
      for (s = 0; s < eff; s++) begin
         if (!slots_written[qnum][s]) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic configure_phase(int phase);
      int q;
      int value;
      drain_results();
      if (phase == 0) begin
         write_reg(mqpf_pkg::CSR_ENABLE, mqpf_pkg::CSR_DATA_W'(1));
         set_queue_count(N_QUEUES);
         for (q = 0; q < N_QUEUES; q++) set_capacity(q, DEPTH);
      end else begin
         write_reg(mqpf_pkg::CSR_ENABLE, ($urandom_range(0, 7) == 0) ? 5'd0 : 5'd1);
         set_queue_count(($urandom_range(0, 9) < 6) ? N_QUEUES : $urandom_range(0, 7));
         for (q = 0; q < N_QUEUES; q++) begin
            case ($urandom_range(0, 5))
               0: value = DEPTH;
               1: value = 1;
               2: value = 2;
               3: value = $urandom_range(1, DEPTH);
               4: value = $urandom_range(0, 31);
               default: value = cap_now[q];
            endcase
            if (value != cap_now[q] && resize_is_safe(q, value)) set_capacity(q, value);
         end
      end
      csr_we <= 1'b0;
   endtask

   task automatic run_random_phase(int n_items, int push_pct);
      int                          i;
      int                          burst_left;
      int                          gap;
      logic                        op;
      logic [mqpf_pkg::QNUM_W-1:0] qnum;
      logic [PKT_W-1:0]            pkt;
      burst_left = $urandom_range(1, 24);
      for (i = 0; i < n_items; i++) begin
         op = ($urandom_range(0, 99) < push_pct) ? mqpf_pkg::OP_PUSH : mqpf_pkg::OP_POP;
         if (live_queues > 0 && $urandom_range(0, 9) < 8) begin
            qnum = mqpf_pkg::QNUM_W'($urandom_range(0, live_queues - 1));
         end else begin
            qnum = mqpf_pkg::QNUM_W'($urandom_range(0, 7));
         end
         case ($urandom_range(0, 15))
            0: pkt = PKT_ONES;
            1: pkt = PKT_ZERO;
            default: pkt = {$urandom, $urandom};
         endcase
         offer_request(op, qnum, pkt);
         burst_left--;
         if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 12);
            gap = $urandom_range(0, 8);
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   endtask

   // Directed checks; every queue is empty again at the end
   task automatic run_directed();
      // disabled block: everything is not initialized, even a bad queue number
      offer_request(mqpf_pkg::OP_PUSH, 3'd0, PKT_ONES);
      offer_request(mqpf_pkg::OP_POP, 3'd7, PKT_ZERO);
      drain_results();
      write_reg(CSR_SPARE6, 5'd31);
      write_reg(CSR_SPARE7, 5'd0);
      write_reg(mqpf_pkg::CSR_ENABLE, 5'd1);
      csr_we <= 1'b0;

      // basic order, empty pop, queue numbers out of range
      offer_request(mqpf_pkg::OP_PUSH, 3'd0, PKT_ONES);
      offer_request(mqpf_pkg::OP_PUSH, 3'd0, PKT_ZERO);
      offer_request(mqpf_pkg::OP_POP, 3'd0, PKT_PATTERN);
      offer_request(mqpf_pkg::OP_POP, 3'd0, PKT_ONES);
      offer_request(mqpf_pkg::OP_POP, 3'd0, PKT_ZERO);
      offer_request(mqpf_pkg::OP_PUSH, 3'd4, PKT_EDGES);
      offer_request(mqpf_pkg::OP_POP, 3'd7, PKT_ZERO);
      offer_request(mqpf_pkg::OP_PUSH, 3'd3, PKT_PATTERN);
      offer_request(mqpf_pkg::OP_POP, 3'd3, PKT_ZERO);
      drain_results();

      // capacity one fills at once; invalid queue wins over zero capacity
      set_queue_count(2);
      set_capacity(1, 1);
      set_capacity(2, 0);
      csr_we <= 1'b0;
      offer_request(mqpf_pkg::OP_PUSH, 3'd1, PKT_EDGES);
      offer_request(mqpf_pkg::OP_PUSH, 3'd1, PKT_ONES);
      offer_request(mqpf_pkg::OP_POP, 3'd1, PKT_ZERO);
      offer_request(mqpf_pkg::OP_POP, 3'd1, PKT_ZERO);
      offer_request(mqpf_pkg::OP_PUSH, 3'd2, PKT_ONES);
      drain_results();

      // oversized queue count and capacity are clamped; zero capacity
      set_queue_count(7);
      set_capacity(3, 31);
      set_capacity(0, 0);
      csr_we <= 1'b0;
      offer_request(mqpf_pkg::OP_PUSH, 3'd2, PKT_ONES);
      offer_request(mqpf_pkg::OP_POP, 3'd0, PKT_ZERO);
      offer_request(mqpf_pkg::OP_PUSH, 3'd3, PKT_EDGES);
      offer_request(mqpf_pkg::OP_POP, 3'd3, PKT_ZERO);
      offer_request(mqpf_pkg::OP_POP, 3'd5, PKT_ZERO);
      drain_results();

      // no queues in use
      set_queue_count(0);
      csr_we <= 1'b0;
      offer_request(mqpf_pkg::OP_PUSH, 3'd0, PKT_PATTERN);
   endtask

   initial begin : stimulus
      int phase;
      int push_pct;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      requests_sent = 0;
      busy_resizes = 0;
      long_holds_asked = 0;
      long_holds_served = 0;
      live_queues = N_QUEUES;
      for (int q = 0; q < N_QUEUES; q++) cap_now[q] = DEPTH;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         configure_phase(phase);
         case ($urandom_range(0, 3))
            0: push_pct = 25;
            3: push_pct = 75;
            default: push_pct = 50;
         endcase
         // first phase leans to pushes so slots get written; the hold phase runs with back-pressure
         if (phase == 0) push_pct = 75;
         if (phase == HOLD_PHASE) begin
            push_pct = 60;
            long_holds_asked++;
         end
         run_random_phase(PHASE_ITEMS, push_pct);
      end

      drain_results();
      $display("mqpf run: %0d requests (directed and %0d random phases), %0d responses checked",
               requests_sent, RANDOM_PHASES, results_checked);
      $display("mqpf run: %0d capacity changes on busy queues, %0d long response holds",
               busy_resizes, long_holds_served);
      if (mismatch_count == 0) begin
         $display("multi_queue_packet_fifo_core_tb passed");
      end else begin
         $display("multi_queue_packet_fifo_core_tb failed");
      end
      $finish;
   end

endmodule
